// File: rtl/bmhq_pkg.sv
package bmhq_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned COUNT_W      = 11;
	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	typedef logic signed [DATA_W-1:0] value_t;

	typedef enum logic [3:0] {
		S_PUSH,
		S_UP,
		S_UPCMP,
		S_WCUR,
		S_DONE,
		S_DROP,
		S_POP,
		S_PEMPTY,
		S_PLAST,
		S_DN,
		S_DNL,
		S_DNR
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_FULL,
		C_EMPTY,
		C_AT_ROOT,
		C_NOT_GREATER,
		C_NO_LEFT,
		C_NO_DESCEND
	} cond_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_PARENT,
		RD_LAST,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CUR,
		WR_RDATA,
		WR_CHILD
	} wr_sel_t;

	typedef enum logic [2:0] {
		POS_HOLD,
		POS_SIZE,
		POS_ZERO,
		POS_PARENT,
		POS_CHILD
	} pos_op_t;

	typedef enum logic [1:0] {
		SZ_HOLD,
		SZ_INC,
		SZ_DEC
	} size_op_t;

	typedef enum logic [2:0] {
		RES_HOLD,
		RES_PUSH_OK,
		RES_DROP,
		RES_EMPTY,
		RES_POP
	} res_op_t;

	typedef struct packed {
		cond_t    cond;
		step_t    jt;
		step_t    jf;
		logic     guard;
		logic     done;
		rd_sel_t  rd;
		wr_sel_t  wr;
		pos_op_t  pos;
		size_op_t size;
		logic     cur_ld;
		logic     best_ld;
		res_op_t  res;
	} ucode_t;

	typedef struct packed {
		logic     start;
		rd_sel_t  rd;
		wr_sel_t  wr;
		pos_op_t  pos;
		size_op_t size;
		logic     cur_ld;
		logic     best_ld;
		res_op_t  res;
		logic     result_ld;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic not_greater;
		logic no_left;
		logic no_descend;
		logic out_block;
	} stat_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '0;
		w.cond = C_ALWAYS;
		w.jt = S_DONE;
		w.jf = S_DONE;
		w.rd = RD_NONE;
		w.wr = WR_NONE;
		w.pos = POS_HOLD;
		w.size = SZ_HOLD;
		w.res = RES_HOLD;
		case (s)
			S_PUSH: begin
				w.cond = C_FULL;
				w.jt = S_DROP;
				w.jf = S_UP;
				w.guard = 1'b1;
				w.pos = POS_SIZE;
				w.size = SZ_INC;
				w.res = RES_PUSH_OK;
			end
			S_UP: begin
				w.cond = C_AT_ROOT;
				w.jt = S_WCUR;
				w.jf = S_UPCMP;
				w.guard = 1'b1;
				w.rd = RD_PARENT;
			end
			S_UPCMP: begin
				w.cond = C_NOT_GREATER;
				w.jt = S_WCUR;
				w.jf = S_UP;
				w.guard = 1'b1;
				w.wr = WR_RDATA;
				w.pos = POS_PARENT;
			end
			S_WCUR: begin
				w.wr = WR_CUR;
			end
			S_DONE: begin
				w.jt = S_DONE;
				w.done = 1'b1;
			end
			S_DROP: begin
				w.res = RES_DROP;
			end
			S_POP: begin
				w.cond = C_EMPTY;
				w.jt = S_PEMPTY;
				w.jf = S_PLAST;
				w.guard = 1'b1;
				w.rd = RD_LAST;
				w.size = SZ_DEC;
				w.res = RES_POP;
			end
			S_PEMPTY: begin
				w.res = RES_EMPTY;
			end
			S_PLAST: begin
				w.cond = C_EMPTY;
				w.jt = S_DONE;
				w.jf = S_DN;
				w.guard = 1'b1;
				w.cur_ld = 1'b1;
				w.pos = POS_ZERO;
			end
			S_DN: begin
				w.cond = C_NO_LEFT;
				w.jt = S_WCUR;
				w.jf = S_DNL;
				w.guard = 1'b1;
				w.rd = RD_LEFT;
			end
			S_DNL: begin
				w.jt = S_DNR;
				w.jf = S_DNR;
				w.rd = RD_RIGHT;
				w.best_ld = 1'b1;
			end
			S_DNR: begin
				w.cond = C_NO_DESCEND;
				w.jt = S_WCUR;
				w.jf = S_DN;
				w.guard = 1'b1;
				w.wr = WR_CHILD;
				w.pos = POS_CHILD;
			end
			default: begin
				w.jt = S_DONE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/bmhq_ram.sv
module bmhq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/bmhq_seq.sv
module bmhq_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             func,
	output logic             in_ready,
	input  bmhq_pkg::stat_t  stat,
	output bmhq_pkg::ctl_t   ctl
);

	import bmhq_pkg::*;

	logic   busy_q, busy_d;
	step_t  step_q, step_d;
	ucode_t uw;
	logic   cond_true;
	logic   stall;
	logic   take;

	assign uw       = ucode_rom(step_q);
	assign take     = in_valid && !busy_q;
	assign stall    = uw.done && stat.out_block;
	assign in_ready = !busy_q;

	always_comb begin
		case (uw.cond)
			C_ALWAYS:      cond_true = 1'b1;
			C_FULL:        cond_true = stat.full;
			C_EMPTY:       cond_true = stat.empty;
			C_AT_ROOT:     cond_true = stat.at_root;
			C_NOT_GREATER: cond_true = stat.not_greater;
			C_NO_LEFT:     cond_true = stat.no_left;
			C_NO_DESCEND:  cond_true = stat.no_descend;
			default:       cond_true = 1'b1;
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		if (!busy_q) begin
			if (take) begin
				busy_d = 1'b1;
				step_d = func ? S_POP : S_PUSH;
			end
		end else if (!stall) begin
			if (uw.done) begin
				busy_d = 1'b0;
			end else begin
				step_d = cond_true ? uw.jt : uw.jf;
			end
		end
	end

	always_comb begin
		ctl = '0;
		ctl.rd = RD_NONE;
		ctl.wr = WR_NONE;
		ctl.pos = POS_HOLD;
		ctl.size = SZ_HOLD;
		ctl.res = RES_HOLD;
		ctl.start = take;
		if (busy_q && !stall && !(uw.guard && cond_true)) begin
			ctl.rd = uw.rd;
			ctl.wr = uw.wr;
			ctl.pos = uw.pos;
			ctl.size = uw.size;
			ctl.cur_ld = uw.cur_ld;
			ctl.best_ld = uw.best_ld;
			ctl.res = uw.res;
		end
		ctl.result_ld = busy_q && uw.done && !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= S_DONE;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

endmodule

// File: rtl/bmhq_dp.sv
module bmhq_dp #(
	parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bmhq_pkg::DATA_W-1:0]    in_data,
	input  bmhq_pkg::ctl_t                 ctl,
	output bmhq_pkg::stat_t                stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bmhq_pkg::DATA_W-1:0]    popped_value,
	output logic [bmhq_pkg::DATA_W-1:0]    top_value,
	output logic [bmhq_pkg::COUNT_W-1:0]   entry_count,
	output logic                           push_dropped
);

	import bmhq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = AW + 2;

	logic [CW-1:0]     size_q;
	logic [AW-1:0]     pos_q;
	value_t            cur_q;
	value_t            bv_q;
	logic              bleft_q;
	logic [DATA_W-1:0] root_q;
	logic [DATA_W-1:0] popped_q;
	logic              dropped_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_popped_q;
	logic [DATA_W-1:0] out_top_q;
	logic [CW-1:0]     out_count_q;
	logic              out_dropped_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;

	logic [AW-1:0]     parent_idx;
	logic [CW-1:0]     last_w;
	logic [XW-1:0]     left_x;
	logic [XW-1:0]     right_x;
	logic [XW-1:0]     size_x;
	logic              take_right;
	logic [DATA_W-1:0] child_val;
	logic [XW-1:0]     child_idx;
	logic [CW+COUNT_W-1:0] count_wide;

	assign parent_idx = (pos_q - AW'(1)) >> 1;
	assign last_w     = size_q - CW'(1);
	assign left_x     = (XW'(pos_q) << 1) + XW'(1);
	assign right_x    = left_x + XW'(1);
	assign size_x     = XW'(size_q);
	assign take_right = (right_x < size_x) && ($signed(rdata) > bv_q);
	assign child_val  = take_right ? rdata : bv_q;
	assign child_idx  = take_right ? right_x : left_x;

	always_comb begin
		stat.full        = size_q == CW'(CAPACITY);
		stat.empty       = size_q == '0;
		stat.at_root     = pos_q == '0;
		stat.not_greater = !(cur_q > $signed(rdata));
		stat.no_left     = left_x >= size_x;
		stat.no_descend  = !take_right && !bleft_q;
		stat.out_block   = out_valid_q && !out_ready;
	end

	always_comb begin
		re = ctl.rd != RD_NONE;
		case (ctl.rd)
			RD_PARENT: raddr = parent_idx;
			RD_LAST:   raddr = last_w[AW-1:0];
			RD_LEFT:   raddr = left_x[AW-1:0];
			RD_RIGHT:  raddr = right_x[AW-1:0];
			default:   raddr = '0;
		endcase
	end

	always_comb begin
		we    = ctl.wr != WR_NONE;
		waddr = pos_q;
		case (ctl.wr)
			WR_CUR:   wdata = cur_q;
			WR_RDATA: wdata = rdata;
			WR_CHILD: wdata = child_val;
			default:  wdata = cur_q;
		endcase
	end

	bmhq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctl.size)
				SZ_INC:  size_q <= size_q + CW'(1);
				SZ_DEC:  size_q <= size_q - CW'(1);
				default: size_q <= size_q;
			endcase
			if (ctl.result_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cur_q <= in_data;
		end else if (ctl.cur_ld) begin
			cur_q <= rdata;
		end
		case (ctl.pos)
			POS_SIZE:   pos_q <= AW'(size_q);
			POS_ZERO:   pos_q <= '0;
			POS_PARENT: pos_q <= parent_idx;
			POS_CHILD:  pos_q <= AW'(child_idx);
			default:    pos_q <= pos_q;
		endcase
		if (ctl.best_ld) begin
			if ($signed(rdata) > cur_q) begin
				bv_q    <= rdata;
				bleft_q <= 1'b1;
			end else begin
				bv_q    <= cur_q;
				bleft_q <= 1'b0;
			end
		end
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		case (ctl.res)
			RES_PUSH_OK: begin
				popped_q  <= '0;
				dropped_q <= 1'b0;
			end
			RES_DROP: begin
				popped_q  <= '0;
				dropped_q <= 1'b1;
			end
			RES_EMPTY: begin
				popped_q  <= EMPTY_VALUE;
				dropped_q <= 1'b0;
			end
			RES_POP: begin
				popped_q  <= root_q;
				dropped_q <= 1'b0;
			end
			default: begin
				popped_q  <= popped_q;
				dropped_q <= dropped_q;
			end
		endcase
		if (ctl.result_ld) begin
			out_popped_q  <= popped_q;
			out_top_q     <= (size_q == '0) ? EMPTY_VALUE : root_q;
			out_count_q   <= size_q;
			out_dropped_q <= dropped_q;
		end
	end

	assign count_wide   = {{COUNT_W{1'b0}}, out_count_q};
	assign out_valid    = out_valid_q;
	assign popped_value = out_popped_q;
	assign top_value    = out_top_q;
	assign entry_count  = count_wide[COUNT_W-1:0];
	assign push_dropped = out_dropped_q;

endmodule

// File: rtl/binary_max_heap_queue_unit.sv
// Binary max-heap priority queue with a microcoded controller.
// Input stream: s_axis_tuser[0] selects the operation (0 push, 1 pop),
// s_axis_tdata carries the signed value to push (ignored on pop).
// Output stream: one transaction per input transaction, carrying the popped
// value (-1 on an empty pop, 0 on push), the maximum after the operation
// (-1 when empty), the entry count and a flag for a push refused when full.
// One item is processed at a time; s_axis_tready is high while idle.
// A push stores the new value at the end and climbs: at each level the parent
// is read and compared, and a smaller parent is moved down, until the value is
// not greater than the parent or reaches the root, where it is written.
// A push to a full heap is refused. A pop takes the root as its result, moves
// the last entry to the root and sinks it, each level reading the left and right
// child and moving the larger one up while it is greater than the sunk value.
// The heap memory has a single read port: one entry is read per cycle, with its
// data registered. s_axis_tready returns in the same cycle as m_axis_tvalid
// rises, so a new item is only taken once the previous one is finished.
// A finished result sits in the output register; the next item is accepted
// and processed meanwhile, and its final step holds until the result is taken.
// Reset empties the heap at once; memory contents need no clearing.
module binary_max_heap_queue_unit #(
	parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // push_value[31:0]
	input  logic [0:0]  s_axis_tuser,  // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // popped_value[31:0], top_value[63:32],
	                                   // entry_count[74:64], push_dropped[75], zero[79:76]
);

	import bmhq_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	logic [DATA_W-1:0]  popped_value;
	logic [DATA_W-1:0]  top_value;
	logic [COUNT_W-1:0] entry_count;
	logic               push_dropped;

	bmhq_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.func    (s_axis_tuser[0]),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	bmhq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (s_axis_tdata),
		.ctl         (ctl),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.popped_value(popped_value),
		.top_value   (top_value),
		.entry_count (entry_count),
		.push_dropped(push_dropped)
	);

	assign m_axis_tdata = {4'b0000, push_dropped, entry_count, top_value, popped_value};

endmodule
